FILE: rtl/mts_pkg.sv
// Package for the min-tracking stack: depth, widths, status and operation codes,
// and the entry and shift-control types shared by the cell row and the top level.
// No dependencies.
package mts_pkg;

  localparam int DEPTH   = 256;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCC_W   = 9;
  localparam int STAT_W  = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] minv;   // minimum of this entry and all below it
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

FILE: rtl/mts_in_if.sv
// Input channel of the min-tracking stack: valid/ready handshake with the
// operation kind and the value to push. Depends on mts_pkg.
interface mts_in_if import mts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: rtl/mts_out_if.sv
// Result channel of the min-tracking stack: valid/ready handshake with popped
// value, current minimum, status and occupancy. Depends on mts_pkg.
interface mts_out_if import mts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] current_min;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_value, output current_min,
                  output status, output occupancy, input ready);
  modport sink   (input valid, input popped_value, input current_min,
                  input status, input occupancy, output ready);
endinterface

FILE: rtl/mts_cell.sv
// One stack cell: holds an entry and loads from its upper neighbor on push
// or its lower neighbor on pop. Depends on mts_pkg.
module mts_cell import mts_pkg::*; (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  entry_t     above,
  input  entry_t     below,
  output entry_t     q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q_r <= above;
    end else if (ctl.pop) begin
      q_r <= below;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/mts_chain.sv
// Row of DEPTH stack cells, cell 0 is the top. Push shifts the row down,
// pop shifts it up. Depends on mts_pkg and mts_cell.
module mts_chain import mts_pkg::*; (
  input  logic       clk,
  input  shift_ctl_t ctl,
  input  entry_t     new_entry,
  output entry_t     top_entry,
  output entry_t     second_entry
);

  entry_t cell_q [DEPTH];

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      entry_t above_w;
      entry_t below_w;
      if (i == 0) begin : g_top
        assign above_w = new_entry;
      end else begin : g_mid
        assign above_w = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_bot
        assign below_w = '0;
      end else begin : g_up
        assign below_w = cell_q[i+1];
      end
      mts_cell u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .above (above_w),
        .below (below_w),
        .q     (cell_q[i])
      );
    end
  endgenerate

  assign top_entry    = cell_q[0];
  assign second_entry = cell_q[1];

endmodule

FILE: rtl/min_tracking_stack_unit.sv
// Top level of the min-tracking stack. Depends on mts_pkg, mts_in_if,
// mts_out_if and mts_chain.
//
// A LIFO of DEPTH signed 32-bit values kept in a row of shift cells, each cell
// holding a value and the running minimum of the stack up to it. The result of
// every transaction (push or pop) is loaded into the output register at the
// accepting edge, so it is offered in the following cycle. One transaction per
// clock is sustained while results are taken, because the whole cell row shifts
// at once. The input is ready whenever the output register is empty or its
// result is being taken in the same cycle; a result that waits blocks the input.
// Pop on empty gives status 1 and push on full gives status 2; both leave the
// stack untouched.
// current_min reads 0 whenever the stack is empty.
module min_tracking_stack_unit import mts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mts_in_if.sink    in_chan,
  mts_out_if.source out_chan
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic signed [DATA_W-1:0] res_popped_r, res_popped_nxt;
  logic signed [DATA_W-1:0] res_min_r, res_min_nxt;
  logic [STAT_W-1:0]        res_status_r, res_status_nxt;
  logic [CNT_W-1:0]         res_count_r;

  logic       accept, empty, full;
  shift_ctl_t ctl;
  entry_t     new_entry, top_entry, second_entry;

  logic signed [DATA_W-1:0] cur_min, push_min;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  assign cur_min  = empty ? '0 : top_entry.minv;
  assign push_min = (!empty && (cur_min < in_chan.value)) ? cur_min : in_chan.value;

  assign ctl.push = accept && (in_chan.kind == KIND_PUSH) && !full;
  assign ctl.pop  = accept && (in_chan.kind == KIND_POP) && !empty;

  assign new_entry.value = in_chan.value;
  assign new_entry.minv  = push_min;

  mts_chain u_chain (
    .clk          (clk),
    .ctl          (ctl),
    .new_entry    (new_entry),
    .top_entry    (top_entry),
    .second_entry (second_entry)
  );

  always_comb begin
    count_nxt      = count_r;
    res_popped_nxt = '0;
    res_min_nxt    = cur_min;
    res_status_nxt = ST_OK;
    if (in_chan.kind == KIND_PUSH) begin
      if (full) begin
        res_status_nxt = ST_FULL;
      end else begin
        count_nxt   = count_r + 1'b1;
        res_min_nxt = push_min;
      end
    end else begin
      if (empty) begin
        res_status_nxt = ST_EMPTY;
      end else begin
        count_nxt      = count_r - 1'b1;
        res_popped_nxt = top_entry.value;
        // last entry leaving: min falls back to 0
        res_min_nxt    = (count_r == CNT_W'(1)) ? '0 : second_entry.minv;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_popped_r <= res_popped_nxt;
      res_min_r    <= res_min_nxt;
      res_status_r <= res_status_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = res_popped_r;
  assign out_chan.current_min  = res_min_r;
  assign out_chan.status       = res_status_r;
  assign out_chan.occupancy    = OCC_W'(res_count_r);

endmodule

FILE: rtl/mts_checker.sv
// Port-level checker for min_tracking_stack_unit, attached by the bind below.
// Depends on mts_pkg.
module mts_checker import mts_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] popped_value,
  input logic signed [DATA_W-1:0] current_min,
  input logic [STAT_W-1:0]        status,
  input logic [OCC_W-1:0]         occupancy
);

  // result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY) |->
      (occupancy == '0) && (popped_value == '0) && (current_min == '0))
    else $error("pop on empty reported nonzero fields");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |->
      (occupancy == OCC_W'(DEPTH)) && (popped_value == '0))
    else $error("push on full with wrong occupancy");

  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (occupancy == '0) && (status == ST_OK) |-> (current_min == '0))
    else $error("empty stack reports nonzero minimum");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .popped_value (out_chan.popped_value),
  .current_min  (out_chan.current_min),
  .status       (out_chan.status),
  .occupancy    (out_chan.occupancy)
);
